[src/assert_macros.svh]
// Assertion helpers shared by the RTL of the volume accumulator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define MSVA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define MSVA_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

[src/msva_pkg.sv]
package msva_pkg;

  // Coordinate width and the widths derived from it.
  localparam int CoordBits = 16;
  localparam int CrossW    = 2 * CoordBits + 1;
  localparam int ProdW     = CoordBits + CrossW;
  localparam int TermW     = 3 * CoordBits + 3;
  localparam int SumW      = 64;

  // Winding codes.
  localparam logic [1:0] WindPos = 2'd1;
  localparam logic [1:0] WindNeg = 2'd2;

  // Division by six: eight quotient bits per cycle.
  localparam int         DivStepBits = 8;
  localparam int         DivCycles   = SumW / DivStepBits;
  localparam logic [3:0] Divisor     = 4'd6;

  // Counter covers both the three vector components and the division cycles.
  localparam int         CntW     = $clog2(DivCycles);
  localparam logic [CntW-1:0] LastComp = CntW'(2);
  localparam logic [CntW-1:0] LastDiv  = CntW'(DivCycles - 1);

  typedef struct packed {
    logic signed [CoordBits-1:0] ax;
    logic signed [CoordBits-1:0] ay;
    logic signed [CoordBits-1:0] az;
    logic signed [CoordBits-1:0] bx;
    logic signed [CoordBits-1:0] by;
    logic signed [CoordBits-1:0] bz;
    logic signed [CoordBits-1:0] cx;
    logic signed [CoordBits-1:0] cy;
    logic signed [CoordBits-1:0] cz;
    logic [1:0]                  winding;
    logic                        final_face;
  } in_item_t;

  typedef struct packed {
    logic signed [SumW-1:0] volume;
    logic                   winding_error;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_SUB,
    ST_DOT,
    ST_ADD,
    ST_ACC,
    ST_PREP,
    ST_DIV,
    ST_OUT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_BC,
    MUL_CB,
    MUL_AN
  } mul_sel_e;

  typedef enum logic [1:0] {
    CROSS_HOLD,
    CROSS_LOAD,
    CROSS_SUB
  } cross_op_e;

  typedef struct packed {
    logic      load;
    mul_sel_e  mul_sel;
    cross_op_e cross_op;
    logic      term_add;
    logic      rotate;
    logic      acc_upd;
    logic      div_prep;
    logic      div_step;
    logic      out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic final_face;
    logic out_busy;
  } dp_status_t;

endpackage

[src/msva_ctrl.sv]
module msva_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  msva_pkg::dp_status_t status_i,
  output msva_pkg::dp_cmd_t    cmd_o
);

  msva_pkg::ctrl_state_e state_q, state_d;
  logic [msva_pkg::CntW-1:0] cnt_q, cnt_d;

  // State and counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= msva_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state: three components of five steps each, then the accumulate,
  // and for the final item the division and the output load.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      msva_pkg::ST_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) state_d = msva_pkg::ST_MUL1;
      end
      msva_pkg::ST_MUL1: state_d = msva_pkg::ST_MUL2;
      msva_pkg::ST_MUL2: state_d = msva_pkg::ST_SUB;
      msva_pkg::ST_SUB:  state_d = msva_pkg::ST_DOT;
      msva_pkg::ST_DOT:  state_d = msva_pkg::ST_ADD;
      msva_pkg::ST_ADD: begin
        if (cnt_q == msva_pkg::LastComp) begin
          cnt_d   = '0;
          state_d = msva_pkg::ST_ACC;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = msva_pkg::ST_MUL1;
        end
      end
      msva_pkg::ST_ACC: begin
        state_d = status_i.final_face ? msva_pkg::ST_PREP : msva_pkg::ST_IDLE;
      end
      msva_pkg::ST_PREP: begin
        cnt_d   = '0;
        state_d = msva_pkg::ST_DIV;
      end
      msva_pkg::ST_DIV: begin
        if (cnt_q == msva_pkg::LastDiv) begin
          cnt_d   = '0;
          state_d = msva_pkg::ST_OUT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      msva_pkg::ST_OUT: begin
        if (!status_i.out_busy) state_d = msva_pkg::ST_IDLE;
      end
      default: begin
        cnt_d   = '0;
        state_d = msva_pkg::ST_IDLE;
      end
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o          = '0;
    cmd_o.mul_sel  = msva_pkg::MUL_NONE;
    cmd_o.cross_op = msva_pkg::CROSS_HOLD;
    in_ready_o     = 1'b0;
    case (state_q)
      msva_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      msva_pkg::ST_MUL1: cmd_o.mul_sel = msva_pkg::MUL_BC;
      msva_pkg::ST_MUL2: begin
        cmd_o.mul_sel  = msva_pkg::MUL_CB;
        cmd_o.cross_op = msva_pkg::CROSS_LOAD;
      end
      msva_pkg::ST_SUB:  cmd_o.cross_op = msva_pkg::CROSS_SUB;
      msva_pkg::ST_DOT:  cmd_o.mul_sel  = msva_pkg::MUL_AN;
      msva_pkg::ST_ADD: begin
        cmd_o.term_add = 1'b1;
        cmd_o.rotate   = 1'b1;
      end
      msva_pkg::ST_ACC:  cmd_o.acc_upd  = 1'b1;
      msva_pkg::ST_PREP: cmd_o.div_prep = 1'b1;
      msva_pkg::ST_DIV:  cmd_o.div_step = 1'b1;
      msva_pkg::ST_OUT:  cmd_o.out_load = !status_i.out_busy;
      default: ;
    endcase
  end

endmodule

[src/msva_datapath.sv]
module msva_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  msva_pkg::in_item_t   in_i,
  input  msva_pkg::dp_cmd_t    cmd_i,
  output msva_pkg::dp_status_t status_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output msva_pkg::out_item_t  out_o
);

  localparam int W      = msva_pkg::CoordBits;
  localparam int CrossW = msva_pkg::CrossW;
  localparam int ProdW  = msva_pkg::ProdW;
  localparam int TermW  = msva_pkg::TermW;
  localparam int SumW   = msva_pkg::SumW;

  localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

  // Vertex registers; they rotate by one component after each dot term,
  // so the cross product always reads the same taps.
  logic signed [W-1:0] a_q [3];
  logic signed [W-1:0] b_q [3];
  logic signed [W-1:0] c_q [3];
  logic [1:0]          wind_q;
  logic                final_q;

  logic signed [ProdW-1:0]  prod_q;
  logic signed [CrossW-1:0] cross_q;
  logic signed [TermW-1:0]  term_q;
  logic signed [SumW-1:0]   sum_q;
  logic                     err_q;
  logic [SumW-1:0]          div_q;
  logic [2:0]               rem_q;
  logic                     neg_q;
  logic                     errsnap_q;
  logic                     out_valid_q;
  msva_pkg::out_item_t      out_q;

  logic signed [W-1:0]      mul_x;
  logic signed [CrossW-1:0] mul_y;
  logic signed [ProdW-1:0]  mul_p;
  logic                     wind_bad;
  logic signed [SumW-1:0]   addend;
  logic signed [SumW:0]     sum_wide;
  logic signed [SumW-1:0]   sum_sat;
  logic [SumW-1:0]          div_d;
  logic [2:0]               rem_d;

  // Shared multiplier operand selection.
  always_comb begin
    case (cmd_i.mul_sel)
      msva_pkg::MUL_BC: begin
        mul_x = b_q[1];
        mul_y = CrossW'(c_q[2]);
      end
      msva_pkg::MUL_CB: begin
        mul_x = b_q[2];
        mul_y = CrossW'(c_q[1]);
      end
      msva_pkg::MUL_AN: begin
        mul_x = a_q[0];
        mul_y = cross_q;
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
    mul_p = mul_x * mul_y;
  end

  // Saturating accumulate; an undefined winding contributes nothing.
  always_comb begin
    wind_bad = (wind_q != msva_pkg::WindPos) && (wind_q != msva_pkg::WindNeg);
    addend   = wind_bad ? '0 : SumW'(term_q);
    sum_wide = (SumW+1)'(sum_q) + (SumW+1)'(addend);
    if (sum_wide[SumW] != sum_wide[SumW-1]) begin
      sum_sat = sum_wide[SumW] ? SumMin : SumMax;
    end else begin
      sum_sat = sum_wide[SumW-1:0];
    end
  end

  // One step of long division by six: eight dividend bits, MSB first,
  // quotient bits shift in at the bottom of the same register.
  always_comb begin
    logic [3:0] r4;
    rem_d = rem_q;
    div_d = div_q;
    for (int i = 0; i < msva_pkg::DivStepBits; i++) begin
      r4    = {rem_d, div_d[SumW-1]};
      div_d = {div_d[SumW-2:0], 1'b0};
      if (r4 >= msva_pkg::Divisor) begin
        rem_d    = 3'(r4 - msva_pkg::Divisor);
        div_d[0] = 1'b1;
      end else begin
        rem_d = r4[2:0];
      end
    end
  end

  // Item and working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q[0]  <= in_i.ax;
      a_q[1]  <= in_i.ay;
      a_q[2]  <= in_i.az;
      b_q[0]  <= in_i.bx;
      b_q[1]  <= in_i.by;
      b_q[2]  <= in_i.bz;
      c_q[0]  <= in_i.cx;
      c_q[1]  <= in_i.cy;
      c_q[2]  <= in_i.cz;
      wind_q  <= in_i.winding;
      final_q <= in_i.final_face;
    end else if (cmd_i.rotate) begin
      a_q[0] <= a_q[1];
      a_q[1] <= a_q[2];
      a_q[2] <= a_q[0];
      b_q[0] <= b_q[1];
      b_q[1] <= b_q[2];
      b_q[2] <= b_q[0];
      c_q[0] <= c_q[1];
      c_q[1] <= c_q[2];
      c_q[2] <= c_q[0];
    end

    if (cmd_i.mul_sel != msva_pkg::MUL_NONE) prod_q <= mul_p;

    case (cmd_i.cross_op)
      msva_pkg::CROSS_LOAD: cross_q <= $signed(prod_q[CrossW-1:0]);
      msva_pkg::CROSS_SUB:  cross_q <= cross_q - $signed(prod_q[CrossW-1:0]);
      default: ;
    endcase

    // A negative winding is the same triple product with its sign turned.
    if (cmd_i.load) begin
      term_q <= '0;
    end else if (cmd_i.term_add) begin
      if (wind_q == msva_pkg::WindNeg) term_q <= term_q - TermW'(prod_q);
      else                             term_q <= term_q + TermW'(prod_q);
    end

    if (cmd_i.div_prep) begin
      neg_q     <= sum_q[SumW-1];
      div_q     <= sum_q[SumW-1] ? $unsigned(-sum_q) : $unsigned(sum_q);
      rem_q     <= '0;
      errsnap_q <= err_q;
    end else if (cmd_i.div_step) begin
      div_q <= div_d;
      rem_q <= rem_d;
    end

    if (cmd_i.out_load) begin
      out_q.volume        <= neg_q ? -$signed(div_q) : $signed(div_q);
      out_q.winding_error <= errsnap_q;
    end
  end

  // Running sum and error flag, cleared once handed to the division.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      err_q <= 1'b0;
    end else if (cmd_i.acc_upd) begin
      sum_q <= sum_sat;
      err_q <= err_q | wind_bad;
    end else if (cmd_i.div_prep) begin
      sum_q <= '0;
      err_q <= 1'b0;
    end
  end

  // Output register valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.final_face = final_q;
  assign status_o.out_busy   = out_valid_q && !out_ready_i;
  assign out_valid_o         = out_valid_q;
  assign out_o               = out_q;

endmodule

[src/mesh_signed_volume_accumulator.sv]
// Signed mesh volume accumulator.
// Input channel (in_valid_i / in_ready_o / in_i) takes one triangle per item:
// three vertices in signed Q8.8, a winding code and a final-face mark.
// Output channel (out_valid_o / out_ready_i / out_o) gives one item per mesh,
// on the final face: the saturated sum of triple products divided by six,
// truncated toward zero, in Q40.24, and the sticky winding error flag.
// One item is in work at a time. The shared multiplier runs five steps per
// vector component; after the accumulate step the input is ready again.
// A final face adds a preparation step, the division steps (eight quotient
// bits each) and an output load, which waits while the output register is busy.
// The output register holds a result while the receiver stalls; the next
// faces are still taken and summed, and only a further result waits in the
// load step until the register drains.
// Reset clears the running sum, the error flag and the output valid.
module mesh_signed_volume_accumulator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  msva_pkg::in_item_t  in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output msva_pkg::out_item_t out_o
);

  msva_pkg::dp_cmd_t    dp_cmd;
  msva_pkg::dp_status_t dp_status;

  // Sequencer.
  msva_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  // Arithmetic and output register.
  msva_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

`include "assert_macros.svh"

  // A result is only loaded into a free output register.
  `MSVA_NEVER(a_load_busy, clk_i, rst_ni, dp_cmd.out_load && dp_status.out_busy, "output overwritten")
  // Once an item is taken, the block is busy in the next cycle.
  `MSVA_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o, "ready after accept")
  // Output valid rises only from a load.
  `MSVA_ASSERT(a_valid_from_load, clk_i, rst_ni, $rose(out_valid_o) |-> $past(dp_cmd.out_load), "spurious output")
  // Division starts only for a final face.
  `MSVA_ASSERT(a_div_on_final, clk_i, rst_ni, dp_cmd.div_prep |-> dp_status.final_face, "result on non-final face")

endmodule
